// ----- hdl/bpf_pkg.sv -----
package bpf_pkg;

    localparam int MAX_ROW_WIDTH = 4096;
    localparam int COUNT_BITS = 16;
    localparam int VALUE_BITS = 32;

    localparam int COL_BITS = $clog2(MAX_ROW_WIDTH);
    localparam int WIDTH_BITS = $clog2(MAX_ROW_WIDTH + 1);
    localparam int ROW_WIDTH_REG_BITS = 13;
    localparam int ROW_WIDTH_RESET = 4096;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_THRESHOLD,
        REG_RUN_ACROSS,
        REG_RUN_DOWN,
        REG_FILL_DATA,
        REG_ROW_WIDTH
    } cfg_index_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] pixel_in;
        logic signed [VALUE_BITS-1:0] variance_in;
    } pix_req_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] pixel_out;
        logic signed [VALUE_BITS-1:0] variance_out;
    } pix_res_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] threshold;
        logic [COUNT_BITS-1:0]        limit_across;
        logic [COUNT_BITS-1:0]        limit_down;
        logic                         fill_all;
        logic [WIDTH_BITS-1:0]        width_use;
    } cfg_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] countdown;
        logic [VALUE_BITS-1:0] variance;
        logic [VALUE_BITS-1:0] pixel;
    } mem_word_t;

endpackage

// ----- hdl/bpf_ram.sv -----
module bpf_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 4096,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/bpf_cfg.sv -----
module bpf_cfg
    import bpf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    logic signed [VALUE_BITS-1:0]   threshold_reg;
    logic [COUNT_BITS-1:0]          across_limit_reg;
    logic [COUNT_BITS-1:0]          down_limit_reg;
    logic                           fill_all_reg;
    logic [ROW_WIDTH_REG_BITS-1:0]  row_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= {1'b0, {(VALUE_BITS-1){1'b1}}};
            across_limit_reg <= '0;
            down_limit_reg   <= '0;
            fill_all_reg     <= 1'b1;
            row_width_reg    <= ROW_WIDTH_REG_BITS'(ROW_WIDTH_RESET);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                REG_THRESHOLD:  threshold_reg    <= cfg_data[VALUE_BITS-1:0];
                REG_RUN_ACROSS: across_limit_reg <= cfg_data[COUNT_BITS-1:0];
                REG_RUN_DOWN:   down_limit_reg   <= cfg_data[COUNT_BITS-1:0];
                REG_FILL_DATA:  fill_all_reg     <= cfg_data[0];
                REG_ROW_WIDTH:  row_width_reg    <= cfg_data[ROW_WIDTH_REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.threshold    = threshold_reg;
        cfg.limit_across = across_limit_reg;
        cfg.limit_down   = down_limit_reg;
        cfg.fill_all     = fill_all_reg;
        if (row_width_reg == '0)
        begin
            cfg.width_use = WIDTH_BITS'(1);
        end
        else if (32'(row_width_reg) > 32'(MAX_ROW_WIDTH))
        begin
            cfg.width_use = WIDTH_BITS'(MAX_ROW_WIDTH);
        end
        else
        begin
            cfg.width_use = WIDTH_BITS'(row_width_reg);
        end
    end

endmodule

// ----- hdl/bad_pixel_fill_with_timeouts.sv -----
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_data (pix_req_t)
// out      output     out_valid / out_ready  out_data (pix_res_t)
// cfg      input      cfg_wr_en              cfg_index, cfg_data
//
// One request is accepted per cycle while in_ready is high; results are registered.
// The rate is set by the single read and single write port of the line memory,
// one read at acceptance and one write when the request leaves the fill stage.
// After reset a clearing pass zeroes every line memory word, countdowns included;
// in_ready stays low during it.
// While a result waits with out_ready low, the output register holds, a request in the
// fill stage holds behind it, and in_ready falls once the fill stage is occupied.
module bad_pixel_fill_with_timeouts
    import bpf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  pix_req_t                  in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output pix_res_t                  out_data,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t cfg;

    logic                  clr_active_reg;
    logic [COL_BITS-1:0]   clr_addr_reg;
    logic [COL_BITS-1:0]   col_reg;
    logic [COL_BITS-1:0]   col_next;
    logic                  s1_valid_reg;
    pix_req_t              s1_req_reg;
    logic [COL_BITS-1:0]   s1_col_reg;
    logic                  s1_last_reg;
    logic                  fwd_hit_reg;
    mem_word_t             fwd_word_reg;
    logic [COUNT_BITS-1:0] across_reg;
    logic [COUNT_BITS-1:0] across_next;
    logic [VALUE_BITS-1:0] prev_pix_reg;
    logic [VALUE_BITS-1:0] prev_var_reg;
    logic                  out_valid_reg;
    pix_res_t              out_data_reg;

    logic                  accept;
    logic                  s1_adv;
    logic                  last_col;
    logic                  bad;
    mem_word_t             ram_q;
    mem_word_t             old_word;
    mem_word_t             wr_word;
    logic [VALUE_BITS-1:0] pix_res;
    logic [VALUE_BITS-1:0] var_res;
    logic [COUNT_BITS-1:0] cd_res;
    logic                  ram_we;
    logic [COL_BITS-1:0]   ram_waddr;
    mem_word_t             ram_wdata;

    bpf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpf_ram #(
        .WIDTH ($bits(mem_word_t)),
        .DEPTH (MAX_ROW_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_q)
    );

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clr_active_reg && (!s1_valid_reg || s1_adv);
    assign accept   = in_valid && in_ready;

    assign last_col = (WIDTH_BITS'(col_reg) + WIDTH_BITS'(1)) >= cfg.width_use;
    assign col_next = last_col ? '0 : col_reg + COL_BITS'(1);

    assign old_word = fwd_hit_reg ? fwd_word_reg : ram_q;
    assign bad      = $signed(s1_req_reg.variance_in) >= cfg.threshold;

    always_comb
    begin
        pix_res     = s1_req_reg.pixel_in;
        var_res     = s1_req_reg.variance_in;
        cd_res      = old_word.countdown;
        across_next = across_reg;
        if (bad)
        begin
            if (across_reg != '0)
            begin
                across_next = across_reg - COUNT_BITS'(1);
                var_res     = prev_var_reg;
                if (cfg.fill_all)
                begin
                    pix_res = prev_pix_reg;
                end
            end
            else if (old_word.countdown != '0)
            begin
                cd_res  = old_word.countdown - COUNT_BITS'(1);
                var_res = old_word.variance;
                if (cfg.fill_all)
                begin
                    pix_res = old_word.pixel;
                end
            end
        end
        else
        begin
            across_next = cfg.limit_across;
            cd_res      = cfg.limit_down;
        end
        if (s1_last_reg)
        begin
            across_next = '0;
        end
        wr_word.countdown = cd_res;
        wr_word.variance  = var_res;
        wr_word.pixel     = cfg.fill_all ? pix_res : old_word.pixel;
    end

    always_comb
    begin
        ram_we    = clr_active_reg || s1_adv;
        ram_waddr = clr_active_reg ? clr_addr_reg : s1_col_reg;
        ram_wdata = clr_active_reg ? mem_word_t'('0) : wr_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            col_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            across_reg     <= '0;
            prev_pix_reg   <= '0;
            prev_var_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + COL_BITS'(1);
                if (clr_addr_reg == COL_BITS'(MAX_ROW_WIDTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                col_reg     <= col_next;
                fwd_hit_reg <= s1_adv && (s1_col_reg == col_reg);
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                across_reg    <= across_next;
                prev_pix_reg  <= pix_res;
                prev_var_reg  <= var_res;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg   <= in_data;
            s1_col_reg   <= col_reg;
            s1_last_reg  <= last_col;
            fwd_word_reg <= wr_word;
        end
        if (s1_adv)
        begin
            out_data_reg.pixel_out    <= pix_res;
            out_data_reg.variance_out <= var_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- hdl/bpf_checker.sv -----
module bpf_checker
    import bpf_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input pix_req_t                  in_data,
    input logic                      out_valid,
    input logic                      out_ready,
    input pix_res_t                  out_data
);

    logic [2:0] flight_reg;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg <= '0;
        end
        else
        begin
            flight_reg <= flight_reg + 3'(in_fire) - 3'(out_fire);
        end
    end

    // A result held for the consumer stays until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    // The clearing pass keeps requests out right after reset.
    assert property (@(posedge clk) $past(!rst_n) && rst_n |-> !in_ready)
        else $error("request taken during the clearing pass");

    // No more than two requests are ever in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        flight_reg <= 3'd2 && (flight_reg != 3'd0 || !out_valid))
        else $error("in-flight request count out of range");

    // A request entering an empty block shows its result once it has passed the fill stage and the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && flight_reg == 3'd0 |=> ##1 out_valid)
        else $error("result missing two cycles after request");

endmodule

bind bad_pixel_fill_with_timeouts bpf_checker u_bpf_checker (.*);
